// File: src/cfl_pkg.sv
// Shared types and constants for the chunk free-list allocator.
// Used by cfl_ctrl, cfl_datapath and the top level; no dependencies.
package cfl_pkg;

    localparam int NUM_CHUNKS = 1024;
    localparam int MAX_RUN    = 64;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int RUN_W  = 7;
    localparam int TYPE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] LIMIT_RST     = CNT_W'(1024);
    localparam logic [CNT_W-1:0] FREE_TOTAL_RST = CNT_W'(NUM_CHUNKS);
    localparam logic [IDX_W-1:0] FREE_TAIL_RST  = IDX_W'(NUM_CHUNKS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_SPLICE = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_RUN = 2'd1,
        ST_SHORT   = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic load_req;
        logic emit_reject;
        logic emit_update;
        logic emit_grant;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic op_alloc;
        logic reject;
        logic grant_last;
        logic out_free;
    } sts_t;

    // An index beyond the heap reads as chunk zero.
    function automatic logic [IDX_W-1:0] safe_idx(input logic [IDX_W-1:0] v);
        safe_idx = (int'(v) < NUM_CHUNKS) ? v : '0;
    endfunction

endpackage

// File: src/cfl_ctrl.sv
// Controller state machine of the chunk free-list allocator.
// Depends on cfl_pkg for the command and status structs.
module cfl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cfl_pkg::sts_t sts,
    output cfl_pkg::cmd_t cmd
);
    import cfl_pkg::*;

    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_EXEC,
        FSM_ALLOC_RD,
        FSM_ALLOC_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            FSM_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_last) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (sts.op_alloc && !sts.reject) begin
                    state_next = FSM_ALLOC_RD;
                end else if (sts.out_free) begin
                    cmd.emit_reject = sts.op_alloc;
                    cmd.emit_update = !sts.op_alloc;
                    state_next      = FSM_IDLE;
                end
            end
            FSM_ALLOC_RD: begin
                // The link read of the current head is in flight.
                state_next = FSM_ALLOC_EMIT;
            end
            FSM_ALLOC_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_grant = 1'b1;
                    state_next     = sts.grant_last ? FSM_IDLE : FSM_ALLOC_RD;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == FSM_IDLE);

endmodule

// File: src/cfl_datapath.sv
// Datapath of the chunk free-list allocator: link memory, list pointers,
// request and limit registers and the result register. Depends on cfl_pkg.
module cfl_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfl_pkg::cmd_t                cmd,
    output cfl_pkg::sts_t                sts,
    input  logic [cfl_pkg::OP_W-1:0]     s_op,
    input  logic [cfl_pkg::RUN_W-1:0]    s_run_length,
    input  logic [cfl_pkg::IDX_W-1:0]    s_chunk_index,
    input  logic [cfl_pkg::TYPE_W-1:0]   s_chunk_type,
    input  logic                         s_shade_grey,
    input  logic                         cfg_we,
    input  logic [cfl_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cfl_pkg::IDX_W-1:0]    m_granted_index,
    output logic                         m_colour_grey,
    output logic [cfl_pkg::TYPE_W-1:0]   m_granted_type,
    output logic                         m_run_last,
    output logic [cfl_pkg::ST_W-1:0]     m_status,
    output logic [cfl_pkg::CNT_W-1:0]    m_free_count
);
    import cfl_pkg::*;

    logic [IDX_W-1:0] link_mem [NUM_CHUNKS];
    logic [IDX_W-1:0] rd_link_reg;
    logic             link_we;
    logic [IDX_W-1:0] link_wa;
    logic [IDX_W-1:0] link_wd;

    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;
    logic [IDX_W-1:0] init_link;

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] free_tail_reg, free_tail_next;
    logic [CNT_W-1:0] free_total_reg, free_total_next;
    logic [IDX_W-1:0] sweep_head_reg, sweep_head_next;
    logic [IDX_W-1:0] sweep_tail_reg, sweep_tail_next;
    logic [CNT_W-1:0] sweep_total_reg, sweep_total_next;
    logic [CNT_W-1:0] limit_reg;

    logic [OP_W-1:0]   req_op_reg;
    logic [RUN_W-1:0]  req_run_reg;
    logic [IDX_W-1:0]  req_cidx_reg;
    logic [TYPE_W-1:0] req_type_reg;
    logic              req_grey_reg;
    logic [RUN_W-1:0]  run_left_reg, run_left_next;

    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic              m_grey_reg;
    logic [TYPE_W-1:0] m_type_reg;
    logic              m_last_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic [CNT_W:0]    lists_total;
    logic              return_ok;
    logic              bad_run;
    logic              short_run;
    logic              emit_any;

    // ---------------- Decode of the latched request ----------------
    assign lists_total = {1'b0, free_total_reg} + {1'b0, sweep_total_reg};
    assign return_ok   = (int'(req_cidx_reg) < NUM_CHUNKS) &&
                         (int'(lists_total) < NUM_CHUNKS);
    assign bad_run     = (req_run_reg == '0) || (int'(req_run_reg) > MAX_RUN) ||
                         ({{(CNT_W-RUN_W){1'b0}}, req_run_reg} > limit_reg);
    assign short_run   = {{(CNT_W-RUN_W){1'b0}}, req_run_reg} > free_total_reg;

    assign init_link = (int'(init_cnt_reg) == NUM_CHUNKS - 1) ?
                       '0 : init_cnt_reg + IDX_W'(1);

    always_comb begin
        sts.init_last  = (int'(init_cnt_reg) == NUM_CHUNKS - 1);
        sts.op_alloc   = (req_op_reg == OP_ALLOC);
        sts.reject     = bad_run || short_run;
        sts.grant_last = (run_left_reg == RUN_W'(1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // ---------------- List pointer updates ----------------
    always_comb begin
        free_head_next   = free_head_reg;
        free_tail_next   = free_tail_reg;
        free_total_next  = free_total_reg;
        sweep_head_next  = sweep_head_reg;
        sweep_tail_next  = sweep_tail_reg;
        sweep_total_next = sweep_total_reg;
        run_left_next    = run_left_reg;
        init_cnt_next    = init_cnt_reg;
        link_we          = 1'b0;
        link_wa          = '0;
        link_wd          = '0;

        if (cmd.init_step) begin
            link_we       = 1'b1;
            link_wa       = init_cnt_reg;
            link_wd       = init_link;
            init_cnt_next = init_link;
        end

        if (cmd.load_req) begin
            run_left_next = s_run_length;
        end

        if (cmd.emit_update) begin
            case (req_op_reg)
                OP_FREE: begin
                    if (return_ok) begin
                        if (free_total_reg == '0) begin
                            free_head_next = req_cidx_reg;
                        end else begin
                            link_we = 1'b1;
                            link_wa = safe_idx(free_tail_reg);
                            link_wd = req_cidx_reg;
                        end
                        free_tail_next  = req_cidx_reg;
                        free_total_next = free_total_reg + CNT_W'(1);
                    end
                end
                OP_SWEEP: begin
                    if (return_ok) begin
                        if (sweep_total_reg == '0) begin
                            sweep_head_next = req_cidx_reg;
                        end else begin
                            link_we = 1'b1;
                            link_wa = safe_idx(sweep_tail_reg);
                            link_wd = req_cidx_reg;
                        end
                        sweep_tail_next  = req_cidx_reg;
                        sweep_total_next = sweep_total_reg + CNT_W'(1);
                    end
                end
                OP_SPLICE: begin
                    if (sweep_total_reg != '0) begin
                        if (free_total_reg == '0) begin
                            free_head_next = sweep_head_reg;
                        end else begin
                            link_we = 1'b1;
                            link_wa = safe_idx(free_tail_reg);
                            link_wd = sweep_head_reg;
                        end
                        free_tail_next   = sweep_tail_reg;
                        free_total_next  = free_total_reg + sweep_total_reg;
                        sweep_head_next  = '0;
                        sweep_tail_next  = '0;
                        sweep_total_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.emit_grant) begin
            free_head_next  = safe_idx(rd_link_reg);
            free_total_next = free_total_reg - CNT_W'(1);
            run_left_next   = run_left_reg - RUN_W'(1);
        end
    end

    // The link of the current head is read every cycle; during a run
    // nothing writes the memory, so the registered data stays current.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        rd_link_reg <= link_mem[free_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg    <= '0;
            free_head_reg   <= '0;
            free_tail_reg   <= FREE_TAIL_RST;
            free_total_reg  <= FREE_TOTAL_RST;
            sweep_head_reg  <= '0;
            sweep_tail_reg  <= '0;
            sweep_total_reg <= '0;
            limit_reg       <= LIMIT_RST;
            run_left_reg    <= '0;
        end else begin
            init_cnt_reg    <= init_cnt_next;
            free_head_reg   <= free_head_next;
            free_tail_reg   <= free_tail_next;
            free_total_reg  <= free_total_next;
            sweep_head_reg  <= sweep_head_next;
            sweep_tail_reg  <= sweep_tail_next;
            sweep_total_reg <= sweep_total_next;
            run_left_reg    <= run_left_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_op_reg   <= s_op;
            req_run_reg  <= s_run_length;
            req_cidx_reg <= s_chunk_index;
            req_type_reg <= s_chunk_type;
            req_grey_reg <= s_shade_grey;
        end
    end

    // ---------------- Result register ----------------
    assign emit_any = cmd.emit_reject || cmd.emit_update || cmd.emit_grant;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_any) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_any) begin
            m_count_reg <= free_total_next;
            if (cmd.emit_grant) begin
                m_index_reg  <= safe_idx(free_head_reg);
                m_grey_reg   <= req_grey_reg;
                m_type_reg   <= req_type_reg;
                m_last_reg   <= sts.grant_last;
                m_status_reg <= ST_OK;
            end else begin
                m_index_reg  <= '0;
                m_grey_reg   <= 1'b0;
                m_type_reg   <= '0;
                m_last_reg   <= 1'b1;
                if (cmd.emit_reject) begin
                    m_status_reg <= bad_run ? ST_BAD_RUN : ST_SHORT;
                end else begin
                    m_status_reg <= ST_OK;
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = m_index_reg;
    assign m_colour_grey   = m_grey_reg;
    assign m_granted_type  = m_type_reg;
    assign m_run_last      = m_last_reg;
    assign m_status        = m_status_reg;
    assign m_free_count    = m_count_reg;

`ifndef SYNTH
    // Ops that return a chunk are refused once every chunk is on a list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(lists_total) <= NUM_CHUNKS)
        else $error("free and sweep totals exceed the heap size");

    // A grant always takes a chunk from a non-empty free list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_grant |-> (free_total_reg != '0) && (run_left_reg != '0))
        else $error("grant issued with an empty free list or no run left");

    // The controller issues at most one result command per cycle,
    // and only when the result register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_reject, cmd.emit_update, cmd.emit_grant}) &&
        (emit_any -> sts.out_free))
        else $error("conflicting or blocked result commands");

    // The link memory is never written while a run is being granted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_grant |-> !link_we)
        else $error("link memory written during an allocation run");
`endif

endmodule

// File: src/chunk_free_list_allocator.sv
// Top level of the chunk free-list allocator.
// Instantiates cfl_ctrl and cfl_datapath; depends on cfl_pkg.
//
// Usage:
//  - Requests arrive on the s_ channel (valid/ready); each transaction is one
//    operation: allocate a run, free a chunk, add a chunk to the sweep list,
//    or splice the sweep list onto the free list.
//  - Results leave on the m_ channel (valid/ready). An allocation yields one
//    transaction per granted chunk, the last one flagged by m_run_last; a
//    refused allocation and every other operation yield a single transaction.
//  - The user writes request_limit (cfg_we/cfg_wdata) only while idle; unchecked.
//  - Sequence: a request is decoded in the cycle after acceptance. A single
//    result is registered from the decode state, and the controller goes idle.
//    An allocation instead alternates a link memory read state and a grant state
//    for each chunk. A new request is taken while the last result still waits
//    for the receiver.
//  - Reset: the link memory is rebuilt one entry per cycle, a pass over every
//    entry with s_ready low; configuration writes are still taken.
//  - A stalled receiver holds the output register and pauses the run.
module chunk_free_list_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cfl_pkg::OP_W-1:0]     s_op,
    input  logic [cfl_pkg::RUN_W-1:0]    s_run_length,
    input  logic [cfl_pkg::IDX_W-1:0]    s_chunk_index,
    input  logic [cfl_pkg::TYPE_W-1:0]   s_chunk_type,
    input  logic                         s_shade_grey,
    input  logic                         cfg_we,
    input  logic [cfl_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cfl_pkg::IDX_W-1:0]    m_granted_index,
    output logic                         m_colour_grey,
    output logic [cfl_pkg::TYPE_W-1:0]   m_granted_type,
    output logic                         m_run_last,
    output logic [cfl_pkg::ST_W-1:0]     m_status,
    output logic [cfl_pkg::CNT_W-1:0]    m_free_count
);
    import cfl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cfl_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_run_length    (s_run_length),
        .s_chunk_index   (s_chunk_index),
        .s_chunk_type    (s_chunk_type),
        .s_shade_grey    (s_shade_grey),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_colour_grey   (m_colour_grey),
        .m_granted_type  (m_granted_type),
        .m_run_last      (m_run_last),
        .m_status        (m_status),
        .m_free_count    (m_free_count)
    );

endmodule

// File: test/chunk_free_list_allocator_test.sv
// Self-checking testbench for chunk_free_list_allocator: random and directed requests,
// checked result by result against a behavioral model of the free and sweep lists.
// Depends on cfl_pkg and the RTL under src/.
`timescale 1ns / 1ps

module chunk_free_list_allocator_test;
    import cfl_pkg::*;

    typedef struct {
        op_t               op;
        logic [RUN_W-1:0]  run;
        logic [IDX_W-1:0]  chunk;
        logic [TYPE_W-1:0] ctype;
        logic              grey;
    } heap_req_t;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic              grey;
        logic [TYPE_W-1:0] ctype;
        logic              last;
        status_t           status;
        logic [CNT_W-1:0]  count;
    } heap_reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op = '0;
    logic [RUN_W-1:0]  s_run_length = '0;
    logic [IDX_W-1:0]  s_chunk_index = '0;
    logic [TYPE_W-1:0] s_chunk_type = '0;
    logic              s_shade_grey = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [IDX_W-1:0]  m_granted_index;
    logic              m_colour_grey;
    logic [TYPE_W-1:0] m_granted_type;
    logic              m_run_last;
    logic [ST_W-1:0]   m_status;
    logic [CNT_W-1:0]  m_free_count;

    // Model of the heap lists.
    logic [IDX_W-1:0] link_mem [NUM_CHUNKS];
    logic [IDX_W-1:0] fl_head, fl_tail, sw_head, sw_tail;
    int               fl_count, sw_count;
    int               run_limit;

    // Chunks granted to the software side and not yet handed back.
    bit               is_held [NUM_CHUNKS];

    heap_req_t        request_queue[$];
    heap_reply_t      predicted_replies[$];
    heap_req_t        on_bus;
    int               failures = 0;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               send_gap = 0;
    int               recv_stall = 0;
    int               hold_ticket = 0;
    int               hold_seen = 0;
    int               hold_left = 0;

    int               phase_limits [5] = '{1023, 1, 64, 5, 1024};
    int               phase_idle [5] = '{30, 25, 20, 35, 0};

    chunk_free_list_allocator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_run_length    (s_run_length),
        .s_chunk_index   (s_chunk_index),
        .s_chunk_type    (s_chunk_type),
        .s_shade_grey    (s_shade_grey),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_colour_grey   (m_colour_grey),
        .m_granted_type  (m_granted_type),
        .m_run_last      (m_run_last),
        .m_status        (m_status),
        .m_free_count    (m_free_count)
    );

    always #1 aclk = ~aclk;

    function automatic heap_reply_t make_reply(input logic [IDX_W-1:0] index, input logic grey,
                                               input logic [TYPE_W-1:0] ctype, input logic last,
                                               input status_t status);
        heap_reply_t y;
        y.index = index;
        y.grey = grey;
        y.ctype = ctype;
        y.last = last;
        y.status = status;
        y.count = CNT_W'(fl_count);
        return y;
    endfunction

    // Advances the list model by one accepted request and queues its replies.
    task automatic track_heap_op(input heap_req_t r);
        logic [IDX_W-1:0] got;
        bit               room;
        room = (fl_count + sw_count) < NUM_CHUNKS;
        if (r.op == OP_ALLOC) begin
            if (r.run == 0 || r.run > MAX_RUN || r.run > run_limit) begin
                predicted_replies.push_back(make_reply('0, 1'b0, '0, 1'b1, ST_BAD_RUN));
            end else if (r.run > fl_count) begin
                predicted_replies.push_back(make_reply('0, 1'b0, '0, 1'b1, ST_SHORT));
            end else begin
                for (int k = 0; k < r.run; k++) begin
                    got = fl_head;
                    fl_head = link_mem[got];
                    fl_count--;
                    is_held[got] = 1'b1;
                    predicted_replies.push_back(make_reply(got, r.grey, r.ctype,
                                                           k == r.run - 1, ST_OK));
                end
            end
        end else begin
            if (room && r.op == OP_FREE) begin
                if (fl_count == 0) fl_head = r.chunk;
                else link_mem[fl_tail] = r.chunk;
                fl_tail = r.chunk;
                fl_count++;
            end else if (room && r.op == OP_SWEEP) begin
                if (sw_count == 0) sw_head = r.chunk;
                else link_mem[sw_tail] = r.chunk;
                sw_tail = r.chunk;
                sw_count++;
            end else if (r.op == OP_SPLICE && sw_count != 0) begin
                if (fl_count == 0) fl_head = sw_head;
                else link_mem[fl_tail] = sw_head;
                fl_tail = sw_tail;
                fl_count += sw_count;
                sw_head = '0;
                sw_tail = '0;
                sw_count = 0;
            end
            predicted_replies.push_back(make_reply('0, 1'b0, '0, 1'b1, ST_OK));
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            failures++;
        end
    endtask

    // Driver: offers the queued requests, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) track_heap_op(on_bus);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    s_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    on_bus = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_op <= on_bus.op;
                    s_run_length <= on_bus.run;
                    s_chunk_index <= on_bus.chunk;
                    s_chunk_type <= on_bus.ctype;
                    s_shade_grey <= on_bus.grey;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction and throttles m_ready.
    always @(posedge aclk) begin
        heap_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    $display("%0t: result with none expected, actual index %0d status %0d",
                             $time, m_granted_index, m_status);
                    failures++;
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("granted_index", want.index, m_granted_index);
                    check_field("colour_grey", want.grey, m_colour_grey);
                    check_field("granted_type", want.ctype, m_granted_type);
                    check_field("run_last", want.last, m_run_last);
                    check_field("status", want.status, m_status);
                    check_field("free_count", want.count, m_free_count);
                end
            end
            // A long hold lets the output register fill and back up the request side.
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_stall = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input op_t op, input int run, input int chunk,
                                 input int ctype, input bit grey);
        heap_req_t r;
        r.op = op;
        r.run = RUN_W'(run);
        r.chunk = IDX_W'(chunk);
        r.ctype = TYPE_W'(ctype);
        r.grey = grey;
        request_queue.push_back(r);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || predicted_replies.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(input int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        run_limit = value;
        @(negedge aclk);
    endtask

    function automatic bit take_held_chunk(output logic [IDX_W-1:0] c);
        int base;
        int j;
        base = $urandom_range(0, NUM_CHUNKS - 1);
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            j = (base + i) % NUM_CHUNKS;
            if (is_held[j]) begin
                is_held[j] = 1'b0;
                c = IDX_W'(j);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mostly well-formed traffic: allocations, returns of chunks actually held,
    // sweep batches followed by splices, plus a little raw noise.
    task automatic run_random_phase(input int n_items);
        heap_req_t        r;
        int               pick;
        int               sel;
        int               lean;
        logic [IDX_W-1:0] c;
        for (int n = 0; n < n_items; n++) begin
            do @(negedge aclk);
            while (request_queue.size() >= 2);
            r.run = RUN_W'($urandom);
            r.chunk = IDX_W'($urandom);
            r.ctype = TYPE_W'($urandom);
            r.grey = 1'($urandom);
            lean = (fl_count < 8) ? 25 : 0;
            pick = $urandom_range(0, 99);
            if (pick < 40 - lean) begin
                r.op = OP_ALLOC;
                sel = $urandom_range(0, 19);
                if (sel < 12) r.run = RUN_W'($urandom_range(1, 4));
                else if (sel < 16) r.run = RUN_W'($urandom_range(5, MAX_RUN));
                else if (sel < 18 && run_limit <= MAX_RUN)
                    r.run = RUN_W'(run_limit + $urandom_range(0, 1));
                else r.run = RUN_W'($urandom_range(0, 127));
            end else if (pick < 86) begin
                r.op = (pick < 70) ? OP_FREE : OP_SWEEP;
                if (!take_held_chunk(c)) r.op = OP_SPLICE;
                else r.chunk = c;
            end else if (pick < 94) begin
                r.op = OP_SPLICE;
            end else begin
                r.op = op_t'($urandom_range(0, 3));
                r.run = RUN_W'($urandom_range(0, 127));
                if (r.op == OP_FREE || r.op == OP_SWEEP) is_held[r.chunk] = 1'b0;
            end
            request_queue.push_back(r);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_CHUNKS; i++) link_mem[i] = IDX_W'((i + 1) % NUM_CHUNKS);
        fl_head = '0;
        fl_tail = FREE_TAIL_RST;
        fl_count = NUM_CHUNKS;
        sw_head = '0;
        sw_tail = '0;
        sw_count = 0;
        run_limit = LIMIT_RST;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        write_limit(1024);

        // Full heap: returns are dropped, an empty sweep list splices to nothing.
        queue_request(OP_FREE, 0, 5, 0, 1'b0);
        queue_request(OP_SWEEP, 127, 1023, 255, 1'b1);
        queue_request(OP_SPLICE, 0, 0, 0, 1'b0);
        // Run lengths of zero and beyond the maximum are refused.
        queue_request(OP_ALLOC, 0, 0, 0, 1'b0);
        queue_request(OP_ALLOC, MAX_RUN + 1, 0, 0, 1'b0);
        queue_request(OP_ALLOC, 127, 1023, 255, 1'b1);
        queue_request(OP_ALLOC, 1, 0, 0, 1'b0);
        queue_request(OP_ALLOC, MAX_RUN, 0, 255, 1'b1);
        // Drain the free list down to 63, refuse a full run, then empty it.
        repeat (14) queue_request(OP_ALLOC, MAX_RUN, $urandom_range(0, NUM_CHUNKS - 1),
                                  $urandom_range(0, 255), 1'($urandom));
        queue_request(OP_ALLOC, MAX_RUN, 0, 17, 1'b1);
        queue_request(OP_ALLOC, MAX_RUN - 1, 0, 200, 1'b0);
        queue_request(OP_ALLOC, 1, 0, 3, 1'b1);
        wait_idle();

        // Rebuild from empty lists, including a splice onto an empty free list.
        is_held[0] = 1'b0;
        is_held[1023] = 1'b0;
        is_held[7] = 1'b0;
        queue_request(OP_FREE, 0, 0, 0, 1'b0);
        queue_request(OP_SWEEP, 0, 1023, 0, 1'b0);
        queue_request(OP_SWEEP, 0, 7, 0, 1'b0);
        queue_request(OP_SPLICE, 0, 0, 0, 1'b0);
        queue_request(OP_ALLOC, 3, 0, 85, 1'b1);
        wait_idle();
        is_held[9] = 1'b0;
        queue_request(OP_SWEEP, 0, 9, 0, 1'b0);
        queue_request(OP_SPLICE, 0, 0, 0, 1'b0);
        queue_request(OP_ALLOC, 1, 0, 170, 1'b0);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_limit(phase_limits[p]);
            send_idle_pct = phase_idle[p];
            recv_idle_pct = phase_idle[p];
            if (p == 2) hold_ticket++;
            run_random_phase(18);
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (failures == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
